### rtl/ifmf_pkg.sv
package ifmf_pkg;

    localparam int unsigned CfgIndexWidth = 8;
    localparam int unsigned CfgDataWidth  = 16;

    localparam logic [CfgIndexWidth-1:0] CFG_STALE_LIMIT = 8'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_SLOW_LIMIT  = 8'd1;

    localparam logic [15:0] STALE_LIMIT_RESET = 16'd100;
    localparam logic [15:0] SLOW_LIMIT_RESET  = 16'd50;

    localparam int unsigned InDataWidth  = 80;
    localparam int unsigned OutDataWidth = 200;

    typedef struct packed {
        logic               kind;
        logic [31:0]        now_ms;
        logic signed [15:0] roll_in;
        logic signed [15:0] pitch_in;
        logic signed [15:0] yaw_in;
    } in_item_t;

    typedef struct packed {
        logic               valid_res;
        logic [31:0]        interval_ms;
        logic [31:0]        slow_events;
        logic [31:0]        stale_events;
        logic [31:0]        sample_count;
        logic signed [15:0] yaw_filtered;
        logic signed [15:0] yaw_latest;
        logic signed [15:0] roll_latest;
        logic signed [15:0] pitch_latest;
    } result_t;

    typedef struct packed {
        logic [15:0] stale_limit_ms;
        logic [15:0] slow_limit_ms;
    } cfg_t;

endpackage

### rtl/ifmf_core.sv
module ifmf_core
    import ifmf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     adv,
    input  in_item_t item,
    input  cfg_t     cfg,
    output result_t  result
);

    logic [31:0]        last_time_reg, last_time_next;
    logic [31:0]        interval_reg, interval_next;
    logic [31:0]        slow_cnt_reg, slow_cnt_next;
    logic [31:0]        stale_cnt_reg, stale_cnt_next;
    logic [31:0]        sample_cnt_reg, sample_cnt_next;
    logic               fresh_reg, fresh_next;
    logic               stale_latch_reg, stale_latch_next;
    logic signed [15:0] filt_yaw_reg, filt_yaw_next;
    logic signed [15:0] roll_reg, roll_next;
    logic signed [15:0] pitch_reg, pitch_next;
    logic signed [15:0] yaw_reg, yaw_next;

    logic        seen;
    logic [31:0] diff;
    logic [16:0] yaw_sum;
    logic        is_stale;

    assign seen    = (last_time_reg != 32'd0);
    assign diff    = item.now_ms - last_time_reg;
    assign yaw_sum = {filt_yaw_reg[15], filt_yaw_reg} + {item.yaw_in[15], item.yaw_in};
    // A new sample resets the age to zero, so only a plain poll can turn stale.
    assign is_stale = !item.kind && seen && (diff > {16'd0, cfg.stale_limit_ms});

    always_comb begin
        last_time_next   = last_time_reg;
        interval_next    = interval_reg;
        slow_cnt_next    = slow_cnt_reg;
        stale_cnt_next   = stale_cnt_reg;
        sample_cnt_next  = sample_cnt_reg;
        fresh_next       = fresh_reg;
        stale_latch_next = stale_latch_reg;
        filt_yaw_next    = filt_yaw_reg;
        roll_next        = roll_reg;
        pitch_next       = pitch_reg;
        yaw_next         = yaw_reg;
        if (item.kind) begin
            roll_next       = item.roll_in;
            pitch_next      = item.pitch_in;
            yaw_next        = item.yaw_in;
            sample_cnt_next = sample_cnt_reg + 32'd1;
            last_time_next  = item.now_ms;
            if (seen) begin
                interval_next = diff;
                if (diff > {16'd0, cfg.slow_limit_ms}) begin
                    slow_cnt_next = slow_cnt_reg + 32'd1;
                end
            end else begin
                interval_next = 32'd0;
            end
            if (!fresh_reg) begin
                filt_yaw_next = item.yaw_in;
            end else begin
                filt_yaw_next = yaw_sum[16:1];
            end
            fresh_next       = 1'b1;
            stale_latch_next = 1'b0;
        end
        if (is_stale) begin
            fresh_next = 1'b0;
            if (!stale_latch_reg) begin
                stale_cnt_next   = stale_cnt_reg + 32'd1;
                stale_latch_next = 1'b1;
            end
        end
    end

    always_comb begin
        result.valid_res    = fresh_next;
        result.interval_ms  = interval_next;
        result.slow_events  = slow_cnt_next;
        result.stale_events = stale_cnt_next;
        result.sample_count = sample_cnt_next;
        result.yaw_filtered = filt_yaw_next;
        result.yaw_latest   = yaw_next;
        result.roll_latest  = roll_next;
        result.pitch_latest = pitch_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_time_reg   <= 32'd0;
            interval_reg    <= 32'd0;
            slow_cnt_reg    <= 32'd0;
            stale_cnt_reg   <= 32'd0;
            sample_cnt_reg  <= 32'd0;
            fresh_reg       <= 1'b0;
            stale_latch_reg <= 1'b0;
            filt_yaw_reg    <= 16'sd0;
            roll_reg        <= 16'sd0;
            pitch_reg       <= 16'sd0;
            yaw_reg         <= 16'sd0;
        end else if (adv) begin
            last_time_reg   <= last_time_next;
            interval_reg    <= interval_next;
            slow_cnt_reg    <= slow_cnt_next;
            stale_cnt_reg   <= stale_cnt_next;
            sample_cnt_reg  <= sample_cnt_next;
            fresh_reg       <= fresh_next;
            stale_latch_reg <= stale_latch_next;
            filt_yaw_reg    <= filt_yaw_next;
            roll_reg        <= roll_next;
            pitch_reg       <= pitch_next;
            yaw_reg         <= yaw_next;
        end
    end

    a_sample_sets_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && item.kind |=> fresh_reg)
        else $error("A sample item did not leave the monitor valid.");

    a_sample_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && item.kind |=> sample_cnt_reg == $past(sample_cnt_reg) + 32'd1)
        else $error("Sample counter did not step on a sample item.");

    a_latch_not_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        stale_latch_reg |-> !fresh_reg)
        else $error("Stale latch is set while the monitor is valid.");

    a_idle_holds_stale: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(stale_cnt_reg) && $stable(last_time_reg))
        else $error("State changed without an item moving forward.");

endmodule

### rtl/imu_freshness_monitor_filter_unit.sv
// IMU freshness monitor with yaw averaging filter.
// Input items arrive on the s_ channel: tuser carries the kind (plain time
// poll or poll with a new attitude sample), tdata the timestamp and angles.
// Every input item produces exactly one result item on the m_ channel with
// the valid flag, the last sample interval, the slow, stale and sample
// counters, the filtered yaw and the latest roll, pitch and yaw.
// The stale and slow limits are written through the cfg_ channel, which is
// always ready; write them only while no item is in flight.
// An accepted item sits in an input register, is processed by a single level
// of logic and is loaded into the output register when that register is free,
// which raises m_tvalid; the result is then taken from the output register.
// One item per cycle is sustained while m_tready is high; the state update is
// the only loop and settles combinationally from the state registers.
// When the receiver stalls, the output register holds its item and the input
// register still takes one more item if it is empty, after which s_tready drops.
// Reset clears all counters, the last update time, the angles and the filter,
// and restores the limits to 100 ms stale and 50 ms slow.
module imu_freshness_monitor_filter_unit
    import ifmf_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // now_ms[31:0], roll_in[47:32], pitch_in[63:48], yaw_in[79:64]
    input  logic [InDataWidth-1:0]   s_tdata,
    // kind
    input  logic                     s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // valid_res[0], interval_ms[32:1], slow_events[64:33], stale_events[96:65],
    // sample_count[128:97], yaw_filtered[144:129], yaw_latest[160:145],
    // roll_latest[176:161], pitch_latest[192:177], zero fill above
    output logic [OutDataWidth-1:0]  m_tdata,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data
);

    logic     in_valid_reg;
    in_item_t in_item_reg;
    logic     out_valid_reg;
    result_t  out_reg;
    result_t  core_result;
    cfg_t     cfg_reg;
    logic     adv;

    assign adv       = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || adv;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;

    assign m_tdata = {7'd0, out_reg.pitch_latest, out_reg.roll_latest, out_reg.yaw_latest,
                      out_reg.yaw_filtered, out_reg.sample_count, out_reg.stale_events,
                      out_reg.slow_events, out_reg.interval_ms, out_reg.valid_res};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stale_limit_ms <= STALE_LIMIT_RESET;
            cfg_reg.slow_limit_ms  <= SLOW_LIMIT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_STALE_LIMIT: cfg_reg.stale_limit_ms <= cfg_data;
                CFG_SLOW_LIMIT:  cfg_reg.slow_limit_ms  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.kind     <= s_tuser;
            in_item_reg.now_ms   <= s_tdata[31:0];
            in_item_reg.roll_in  <= s_tdata[47:32];
            in_item_reg.pitch_in <= s_tdata[63:48];
            in_item_reg.yaw_in   <= s_tdata[79:64];
        end
        if (adv) begin
            out_reg <= core_result;
        end
    end

    ifmf_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (core_result)
    );

endmodule
